[hdl/symbol_histogram_fingerprint_assert.svh]
// assertion macros shared by the histogram block
// no dependencies
`ifndef SYMBOL_HISTOGRAM_FINGERPRINT_ASSERT_SVH
`define SYMBOL_HISTOGRAM_FINGERPRINT_ASSERT_SVH
`define SHF_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SHF_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hdl/shf_pkg.sv]
// types, constants and command structs for the histogram block
// no dependencies
package shf_pkg;
    localparam int SYMBOLS     = 64;
    localparam int MAX_REGIONS = 16;
    localparam int COUNT_BITS  = 32;
    localparam int OFFSET_BITS = 32;
    localparam int SYM_W  = $clog2(SYMBOLS);
    localparam int REG_W  = $clog2(MAX_REGIONS);
    localparam int SLOT_W = $clog2(MAX_REGIONS + 1);
    localparam int PROD_W = OFFSET_BITS + SLOT_W;
    localparam int QCNT_W = $clog2(PROD_W + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    localparam logic [1:0] ACT_COUNT = 2'd0;
    localparam logic [1:0] ACT_EMPTY = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] SEL_TOTAL  = 2'd0;
    localparam logic [1:0] SEL_REGION = 2'd1;
    localparam logic [1:0] SEL_PAIR   = 2'd2;
    localparam logic [1:0] SEL_EVENT  = 2'd3;

    localparam logic [0:0] ADDR_TOTAL_BYTES = 1'd0;
    localparam logic [0:0] ADDR_SLOTS       = 1'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic        event_start;
        logic [5:0]  symbol;
        logic [31:0] evt_offset;
        logic [1:0]  table_select;
        logic [5:0]  read_row;
        logic [5:0]  read_col;
    } t_in_item;

    typedef struct packed {
        logic [31:0] count_value;
        logic        saturated;
    } t_out_item;

    // memory select for one read-modify-write
    typedef enum logic [1:0] {
        MEM_TOT = 2'd0,
        MEM_REG = 2'd1,
        MEM_PAIR = 2'd2
    } t_mem;

    typedef struct packed {
        logic load;      // latch input item
        logic div_start;
        logic rd;        // issue memory read
        t_mem mem;
        logic wr;        // write bumped value back
        logic ev_bump;
        logic hist_upd;
        logic rd_done;   // capture read result
        logic clr_step;
        logic clr_regs;
    } t_cmd;

    typedef struct packed {
        logic       div_busy;
        logic       clr_last;
        logic [1:0] action;
        logic       sym_ok;
        logic       have_last;
        logic       start;
    } t_sts;
endpackage

[hdl/shf_datapath.sv]
// datapath: region divider, counter memories, event counter, read path
// depends on shf_pkg
`include "symbol_histogram_fingerprint_assert.svh"
module shf_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  shf_pkg::t_cmd         i_cmd,
    output shf_pkg::t_sts         o_sts,
    input  shf_pkg::t_in_item     i_item,
    input  logic [31:0]           i_total_bytes,
    input  logic [4:0]            i_slots,
    output shf_pkg::t_out_item    o_result
);
    localparam int SW = shf_pkg::SYM_W;
    localparam int RW = shf_pkg::REG_W;
    localparam int PW = shf_pkg::PROD_W;
    localparam int CW = shf_pkg::COUNT_BITS;
    localparam int RA_W = RW + SW;
    localparam int PA_W = 2 * SW;

    shf_pkg::t_in_item r_item;
    logic [shf_pkg::SLOT_W-1:0] r_slots;

    // slots in use
    logic [shf_pkg::SLOT_W-1:0] slots_use;
    always_comb begin
        if (i_slots == '0) slots_use = shf_pkg::SLOT_W'(1);
        else if ({1'b0, i_slots} > 6'(shf_pkg::MAX_REGIONS))
            slots_use = shf_pkg::SLOT_W'(shf_pkg::MAX_REGIONS);
        else slots_use = shf_pkg::SLOT_W'(i_slots);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_slots <= slots_use;
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [PW-1:0] r_num, n_num;
    logic [PW:0]   r_rem, n_rem;
    logic [shf_pkg::QCNT_W-1:0] r_qcnt, n_qcnt;
    logic r_busy, n_busy;
    logic [PW:0] trial;
    always_comb begin
        n_num = r_num; n_rem = r_rem; n_qcnt = r_qcnt; n_busy = r_busy;
        trial = {r_rem[PW-1:0], r_num[PW-1]};
        if (i_cmd.div_start) begin
            n_num  = PW'(r_item.evt_offset[shf_pkg::OFFSET_BITS-1:0]) * PW'(r_slots);
            n_rem  = '0;
            n_qcnt = shf_pkg::QCNT_W'(PW);
            n_busy = (i_total_bytes != '0);
        end else if (r_busy) begin
            if (trial >= (PW+1)'(i_total_bytes)) begin
                n_rem = trial - (PW+1)'(i_total_bytes);
                n_num = {r_num[PW-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_num = {r_num[PW-2:0], 1'b0};
            end
            n_qcnt = r_qcnt - 1'b1;
            if (r_qcnt == shf_pkg::QCNT_W'(1)) n_busy = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_qcnt <= n_qcnt;
    end

    logic [RW-1:0] region;
    always_comb begin
        if (i_total_bytes == '0) region = '0;
        else if (r_num >= PW'(r_slots)) region = RW'(r_slots - 1'b1);
        else region = RW'(r_num);
    end

    // history and event count
    logic [SW-1:0] r_last;
    logic r_have_last;
    logic [CW-1:0] r_events;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_regs) begin
            r_last <= '0; r_have_last <= 1'b0; r_events <= '0;
        end else begin
            if (i_cmd.ev_bump && r_events != shf_pkg::CNT_MAX) r_events <= r_events + 1'b1;
            if (i_cmd.hist_upd) begin
                r_last <= r_item.symbol[SW-1:0]; r_have_last <= 1'b1;
            end
        end
    end

    // clear sweep counter covers the largest memory
    logic [PA_W-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
    end

    logic [CW-1:0] mem_tot  [shf_pkg::SYMBOLS];
    logic [CW-1:0] mem_reg  [shf_pkg::MAX_REGIONS * shf_pkg::SYMBOLS];
    logic [CW-1:0] mem_pair [shf_pkg::SYMBOLS * shf_pkg::SYMBOLS];

    logic [SW-1:0]   a_tot;
    logic [RA_W-1:0] a_reg;
    logic [PA_W-1:0] a_pair;
    logic is_read;
    assign is_read = (r_item.action == shf_pkg::ACT_READ);
    always_comb begin
        if (is_read) begin
            a_tot  = r_item.read_col[SW-1:0];
            a_reg  = {r_item.read_row[RW-1:0], r_item.read_col[SW-1:0]};
            a_pair = {r_item.read_row[SW-1:0], r_item.read_col[SW-1:0]};
        end else begin
            a_tot  = r_item.symbol[SW-1:0];
            a_reg  = {region, r_item.symbol[SW-1:0]};
            a_pair = {r_last, r_item.symbol[SW-1:0]};
        end
    end

    logic [CW-1:0] r_q_tot, r_q_reg, r_q_pair, q_sel, bumped;
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_q_tot  <= mem_tot[a_tot];
            r_q_reg  <= mem_reg[a_reg];
            r_q_pair <= mem_pair[a_pair];
        end
    end
    always_comb begin
        unique case (i_cmd.mem)
            shf_pkg::MEM_TOT:  q_sel = r_q_tot;
            shf_pkg::MEM_REG:  q_sel = r_q_reg;
            default:           q_sel = r_q_pair;
        endcase
    end
    assign bumped = (q_sel == shf_pkg::CNT_MAX) ? q_sel : q_sel + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem_pair[r_clr] <= '0;
            mem_reg[r_clr[RA_W-1:0]] <= '0;
            mem_tot[r_clr[SW-1:0]] <= '0;
        end else if (i_cmd.wr) begin
            unique case (i_cmd.mem)
                shf_pkg::MEM_TOT:  mem_tot[a_tot] <= bumped;
                shf_pkg::MEM_REG:  mem_reg[a_reg] <= bumped;
                default:           mem_pair[a_pair] <= bumped;
            endcase
        end
    end

    // read result
    logic [CW-1:0] rv;
    logic ok;
    always_comb begin
        rv = '0; ok = 1'b0;
        unique case (r_item.table_select)
            shf_pkg::SEL_TOTAL: begin
                ok = 1'b1; rv = r_q_tot;
            end
            shf_pkg::SEL_REGION: begin
                ok = ({1'b0, r_item.read_row} < 7'(r_slots)); rv = ok ? r_q_reg : '0;
            end
            shf_pkg::SEL_PAIR: begin
                ok = 1'b1; rv = r_q_pair;
            end
            default: begin
                ok = 1'b1; rv = r_events;
            end
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_done) begin
            o_result.count_value <= rv[31:0];
            o_result.saturated   <= ok && (rv == shf_pkg::CNT_MAX);
        end
    end

    assign o_sts.div_busy  = r_busy;
    assign o_sts.clr_last  = (r_clr == '1);
    assign o_sts.action    = r_item.action;
    assign o_sts.sym_ok    = 1'b1;
    assign o_sts.have_last = r_have_last;
    assign o_sts.start     = r_item.event_start;

    `SHF_ASSERT_NXT(a_div_ends, i_clk, i_rst_n, r_busy && r_qcnt == shf_pkg::QCNT_W'(1), !r_busy)
    `SHF_ASSERT_IMP(a_no_wr_clr, i_clk, i_rst_n, i_cmd.clr_step, !i_cmd.wr)
    `SHF_ASSERT_IMP(a_rd_wr, i_clk, i_rst_n, i_cmd.wr, !i_cmd.rd)
endmodule

[hdl/shf_ctrl.sv]
// controller: sequences divide, read-modify-writes, reads and clears
// depends on shf_pkg
`include "symbol_histogram_fingerprint_assert.svh"
module shf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output shf_pkg::t_cmd  o_cmd,
    input  shf_pkg::t_sts  i_sts
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_WTOT  = 10'b0000010000,
        S_WREG  = 10'b0000100000,
        S_WPAIR = 10'b0001000000,
        S_RDQ   = 10'b0010000000,
        S_RES   = 10'b0100000000,
        S_CLR   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic r_ovalid, n_ovalid;
    logic acc;

    // a pending result may wait in the output register while a new item is taken
    assign o_in_ready = (r_state == S_IDLE);
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state; n_ovalid = r_ovalid;
        o_cmd = '0;
        o_cmd.mem = shf_pkg::MEM_TOT;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = acc;
                if (acc) n_state = S_DISP;
            end
            S_DISP: begin
                unique case (i_sts.action)
                    shf_pkg::ACT_COUNT: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.ev_bump = i_sts.start;
                        n_state = S_DIV;
                    end
                    shf_pkg::ACT_EMPTY: begin
                        o_cmd.ev_bump = 1'b1; n_state = S_IDLE;
                    end
                    shf_pkg::ACT_READ: begin
                        o_cmd.rd = 1'b1; n_state = S_RDQ;
                    end
                    default: begin
                        o_cmd.clr_regs = 1'b1; n_state = S_CLR;
                    end
                endcase
            end
            S_DIV: if (!i_sts.div_busy) begin
                o_cmd.rd = 1'b1; n_state = S_WTOT;
            end
            S_WTOT: begin
                o_cmd.wr = 1'b1; o_cmd.mem = shf_pkg::MEM_TOT; n_state = S_WREG;
            end
            S_WREG: begin
                o_cmd.wr = 1'b1; o_cmd.mem = shf_pkg::MEM_REG; n_state = S_WPAIR;
            end
            S_WPAIR: begin
                o_cmd.wr = i_sts.have_last; o_cmd.mem = shf_pkg::MEM_PAIR;
                o_cmd.hist_upd = 1'b1; n_state = S_IDLE;
            end
            S_RD: n_state = S_IDLE;
            S_RDQ: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.rd_done = 1'b1; n_ovalid = 1'b1; n_state = S_RES;
                end
            end
            S_RES: n_state = S_IDLE;
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

    `SHF_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `SHF_ASSERT_IMP(a_clr_no_acc, i_clk, i_rst_n, r_state == S_CLR, !o_in_ready)
    `SHF_ASSERT_NXT(a_cap, i_clk, i_rst_n, o_cmd.rd_done, r_ovalid)
endmodule

[hdl/symbol_histogram_fingerprint.sv]
// Symbol histogram with pair counts. No new item is accepted until the current one is done.
// A count item runs the 37-step restoring divider that finds the region (skipped when
// total_bytes is 0), then three counter read-modify-writes; an empty event bumps the event
// counter, a read may wait on the output, and clear sweeps the 4096-entry pair memory.
// After reset the same clearing pass runs before the first item is accepted;
// configuration should be written while no item is in flight.
// depends on shf_pkg, shf_ctrl, shf_datapath
module symbol_histogram_fingerprint (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  shf_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output shf_pkg::t_out_item   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:2]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic [31:0] r_total_bytes;
    logic [4:0]  r_slots;
    shf_pkg::t_cmd cmd;
    shf_pkg::t_sts sts;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_bytes <= '0; r_slots <= 5'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                shf_pkg::ADDR_TOTAL_BYTES: r_total_bytes <= pwdata;
                default:                   r_slots <= pwdata[4:0];
            endcase
        end
    end
    assign prdata = (paddr == shf_pkg::ADDR_SLOTS) ? {27'd0, r_slots} : r_total_bytes;

    shf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .o_cmd(cmd), .i_sts(sts)
    );
    shf_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .i_item(i_in_data),
        .i_total_bytes(r_total_bytes), .i_slots(r_slots), .o_result(o_out_data)
    );
endmodule
